// File: sv/irkh_pkg.sv
package irkh_pkg;

  localparam int TimeW    = 32;
  localparam int CodeW    = 8;
  localparam int MsW      = 16;
  localparam int JoyW     = 12;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [TimeW-1:0] BackReleaseMs = 32'd200;
  localparam logic [JoyW-1:0]  JoyLow        = 12'd500;
  localparam logic [JoyW-1:0]  JoyHigh       = 12'd3500;

  localparam logic [CodeW-1:0] CodeUpRst     = 8'd24;
  localparam logic [CodeW-1:0] CodeDownRst   = 8'd82;
  localparam logic [CodeW-1:0] CodeLeftRst   = 8'd8;
  localparam logic [CodeW-1:0] CodeRightRst  = 8'd90;
  localparam logic [CodeW-1:0] CodeOkRst     = 8'd28;
  localparam logic [CodeW-1:0] CodeBackRst   = 8'd22;
  localparam logic [MsW-1:0]   LongPressRst  = 16'd800;
  localparam logic [MsW-1:0]   DirHoldRst    = 16'd180;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CODE_UP    = 3'd0,
    CFG_CODE_DOWN  = 3'd1,
    CFG_CODE_LEFT  = 3'd2,
    CFG_CODE_RIGHT = 3'd3,
    CFG_CODE_OK    = 3'd4,
    CFG_CODE_BACK  = 3'd5,
    CFG_LONG_PRESS = 3'd6,
    CFG_DIR_HOLD   = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_UP    = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_t;

  typedef struct packed {
    logic [CodeW-1:0] code_up;
    logic [CodeW-1:0] code_down;
    logic [CodeW-1:0] code_left;
    logic [CodeW-1:0] code_right;
    logic [CodeW-1:0] code_ok;
    logic [CodeW-1:0] code_back;
    logic [MsW-1:0]   long_press_ms;
    logic [MsW-1:0]   dir_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             frame_valid;
    logic             frame_repeat;
    logic [CodeW-1:0] frame_cmd;
    logic [JoyW-1:0]  joy_x_in;
    logic [JoyW-1:0]  joy_y_in;
    logic             click_in;
    logic             short_in;
    logic             any_in;
  } poll_t;

  typedef struct packed {
    logic [JoyW-1:0] joy_x_out;
    logic [JoyW-1:0] joy_y_out;
    logic            click_out;
    logic            short_back;
    logic            long_back;
    logic            any_activity;
  } result_t;

endpackage

// File: sv/irkh_if.sv
interface irkh_poll_if import irkh_pkg::*; ();
  logic  valid;
  logic  ready;
  poll_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface irkh_result_if import irkh_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// File: sv/ir_remote_key_hold_qualifier_core.sv
// IR remote key hold qualifier. One poll beat in gives one result beat out; a new poll is
// taken every cycle while the output is not stalled. A poll is held in an input register,
// evaluated combinationally against the held direction and BACK timing state, and the
// result is kept in an output register. While a result waits, one more poll is taken into the
// input register and then the input stalls until the result is accepted. Config
// registers (cfg_we, cfg_index, cfg_data) must only be written while no poll is in flight.
module ir_remote_key_hold_qualifier_core import irkh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  irkh_poll_if.sink           poll,
  irkh_result_if.source       result
);

  cfg_t    cfg;
  logic    stage_valid;
  poll_t   stage_item;
  logic    out_valid;
  result_t out_item;
  result_t eval_res;
  logic    advance;

  irkh_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  irkh_eval u_eval (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .cfg  (cfg),
    .item (stage_item),
    .res  (eval_res)
  );

  assign advance      = stage_valid && (!out_valid || result.ready);
  assign poll.ready   = !stage_valid || advance;
  assign result.valid = out_valid;
  assign result.item  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (poll.ready) begin
      stage_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.ready && poll.valid) begin
      stage_item <= poll.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= eval_res;
    end
  end

endmodule

// File: sv/irkh_cfg_regs.sv
module irkh_cfg_regs import irkh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_up       <= CodeUpRst;
      cfg.code_down     <= CodeDownRst;
      cfg.code_left     <= CodeLeftRst;
      cfg.code_right    <= CodeRightRst;
      cfg.code_ok       <= CodeOkRst;
      cfg.code_back     <= CodeBackRst;
      cfg.long_press_ms <= LongPressRst;
      cfg.dir_hold_ms   <= DirHoldRst;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CODE_UP:    cfg.code_up       <= cfg_data[CodeW-1:0];
        CFG_CODE_DOWN:  cfg.code_down     <= cfg_data[CodeW-1:0];
        CFG_CODE_LEFT:  cfg.code_left     <= cfg_data[CodeW-1:0];
        CFG_CODE_RIGHT: cfg.code_right    <= cfg_data[CodeW-1:0];
        CFG_CODE_OK:    cfg.code_ok       <= cfg_data[CodeW-1:0];
        CFG_CODE_BACK:  cfg.code_back     <= cfg_data[CodeW-1:0];
        CFG_LONG_PRESS: cfg.long_press_ms <= cfg_data[MsW-1:0];
        CFG_DIR_HOLD:   cfg.dir_hold_ms   <= cfg_data[MsW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/irkh_eval.sv
module irkh_eval import irkh_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  cfg_t    cfg,
  input  poll_t   item,
  output result_t res
);

  dir_t             held_direction, held_direction_next;
  logic [TimeW-1:0] dir_last_seen, dir_last_seen_next;
  logic             back_holding, back_holding_next;
  logic [TimeW-1:0] back_start_time, back_start_time_next;
  logic [TimeW-1:0] back_last_seen, back_last_seen_next;
  logic             long_hit, short_hit;

  always_comb begin
    logic             fresh;
    logic             is_up, is_down, is_left, is_right, is_dir;
    logic [TimeW-1:0] dir_age, back_age, idle_age;
    logic             click, any;
    logic [JoyW-1:0]  jx, jy;

    held_direction_next  = held_direction;
    dir_last_seen_next   = dir_last_seen;
    back_holding_next    = back_holding;
    back_start_time_next = back_start_time;
    back_last_seen_next  = back_last_seen;
    click     = item.click_in;
    any       = item.any_in;
    jx        = item.joy_x_in;
    jy        = item.joy_y_in;
    long_hit  = 1'b0;
    short_hit = 1'b0;

    fresh    = item.frame_valid && !item.frame_repeat;
    is_up    = item.frame_cmd == cfg.code_up;
    is_down  = item.frame_cmd == cfg.code_down;
    is_left  = item.frame_cmd == cfg.code_left;
    is_right = item.frame_cmd == cfg.code_right;
    is_dir   = is_up || is_down || is_left || is_right;

    if (item.frame_valid && item.frame_repeat) begin
      if (held_direction != DIR_NONE) dir_last_seen_next = item.now_ms;
      if (back_holding) back_last_seen_next = item.now_ms;
    end else if (fresh && is_dir) begin
      if (is_up) held_direction_next = DIR_UP;
      else if (is_down) held_direction_next = DIR_DOWN;
      else if (is_left) held_direction_next = DIR_LEFT;
      else held_direction_next = DIR_RIGHT;
      dir_last_seen_next = item.now_ms;
    end else if (fresh && item.frame_cmd == cfg.code_ok) begin
      click = 1'b1;
      any   = 1'b1;
    end else if (fresh && item.frame_cmd == cfg.code_back) begin
      back_holding_next    = 1'b1;
      back_start_time_next = item.now_ms;
      back_last_seen_next  = item.now_ms;
    end

    dir_age = item.now_ms - dir_last_seen_next;
    if (held_direction_next != DIR_NONE &&
        dir_age >= {{(TimeW-MsW){1'b0}}, cfg.dir_hold_ms})
      held_direction_next = DIR_NONE;

    case (held_direction_next)
      DIR_UP: begin
        jy  = JoyLow;
        any = 1'b1;
      end
      DIR_DOWN: begin
        jy  = JoyHigh;
        any = 1'b1;
      end
      DIR_LEFT: begin
        jx  = JoyLow;
        any = 1'b1;
      end
      DIR_RIGHT: begin
        jx  = JoyHigh;
        any = 1'b1;
      end
      default: held_direction_next = DIR_NONE;
    endcase

    back_age = item.now_ms - back_start_time_next;
    idle_age = item.now_ms - back_last_seen_next;
    if (back_holding_next) begin
      if (back_age >= {{(TimeW-MsW){1'b0}}, cfg.long_press_ms}) begin
        long_hit          = 1'b1;
        back_holding_next = 1'b0;
      end else if (idle_age >= BackReleaseMs) begin
        short_hit         = 1'b1;
        any               = 1'b1;
        back_holding_next = 1'b0;
      end
    end

    res.joy_x_out    = jx;
    res.joy_y_out    = jy;
    res.click_out    = click;
    res.short_back   = item.short_in || short_hit;
    res.long_back    = long_hit;
    res.any_activity = any;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_direction  <= DIR_NONE;
      dir_last_seen   <= '0;
      back_holding    <= 1'b0;
      back_start_time <= '0;
      back_last_seen  <= '0;
    end else if (fire) begin
      held_direction  <= held_direction_next;
      dir_last_seen   <= dir_last_seen_next;
      back_holding    <= back_holding_next;
      back_start_time <= back_start_time_next;
      back_last_seen  <= back_last_seen_next;
    end
  end

  a_long_short_excl: assert property (@(posedge clk) disable iff (rst)
    !(long_hit && short_hit))
    else $error("long and short back in the same beat");

  a_idle_state_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(held_direction) && $stable(back_holding))
    else $error("key state moved without a beat");

  a_back_release: assert property (@(posedge clk) disable iff (rst)
    fire && (long_hit || short_hit) |=> !back_holding)
    else $error("BACK still held after release");

  a_dir_override: assert property (@(posedge clk) disable iff (rst)
    fire && held_direction_next == DIR_UP |-> res.joy_y_out == JoyLow && res.any_activity)
    else $error("up held without Y override");

endmodule

// File: tb/tb_ir_remote_key_hold_qualifier_core.sv
`timescale 1ns / 1ps

module tb_ir_remote_key_hold_qualifier_core;
  import irkh_pkg::*;

  localparam int StallLimit = 2000;
  localparam int DrainCycles = 4;
  localparam cfg_t DefaultCfg = '{CodeUpRst, CodeDownRst, CodeLeftRst, CodeRightRst,
                                  CodeOkRst, CodeBackRst, LongPressRst, DirHoldRst};

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  irkh_poll_if   poll_bus ();
  irkh_result_if result_bus ();

  ir_remote_key_hold_qualifier_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .poll      (poll_bus),
    .result    (result_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's registers and hold state
  cfg_t             cfg_shadow;
  dir_t             hold_dir;
  logic [TimeW-1:0] hold_dir_stamp;
  logic             back_timing;
  logic [TimeW-1:0] back_press_stamp;
  logic [TimeW-1:0] back_refresh_stamp;

  result_t          expected_results[$];
  logic [TimeW-1:0] poll_ms;
  int               mismatch_count = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               sink_hold_left = 0;
  int               stall_cycles = 0;

  function automatic result_t predict_poll(input poll_t p);
    result_t          r;
    logic [TimeW-1:0] since;
    r.joy_x_out    = p.joy_x_in;
    r.joy_y_out    = p.joy_y_in;
    r.click_out    = p.click_in;
    r.short_back   = p.short_in;
    r.long_back    = 1'b0;
    r.any_activity = p.any_in;
    if (p.frame_valid) begin
      if (p.frame_repeat) begin
        if (hold_dir != DIR_NONE) hold_dir_stamp = p.now_ms;
        if (back_timing) back_refresh_stamp = p.now_ms;
      end else if (p.frame_cmd == cfg_shadow.code_up) begin
        hold_dir = DIR_UP;
        hold_dir_stamp = p.now_ms;
      end else if (p.frame_cmd == cfg_shadow.code_down) begin
        hold_dir = DIR_DOWN;
        hold_dir_stamp = p.now_ms;
      end else if (p.frame_cmd == cfg_shadow.code_left) begin
        hold_dir = DIR_LEFT;
        hold_dir_stamp = p.now_ms;
      end else if (p.frame_cmd == cfg_shadow.code_right) begin
        hold_dir = DIR_RIGHT;
        hold_dir_stamp = p.now_ms;
      end else if (p.frame_cmd == cfg_shadow.code_ok) begin
        r.click_out = 1'b1;
        r.any_activity = 1'b1;
      end else if (p.frame_cmd == cfg_shadow.code_back) begin
        back_timing = 1'b1;
        back_press_stamp = p.now_ms;
        back_refresh_stamp = p.now_ms;
      end
    end
    since = p.now_ms - hold_dir_stamp;
    if (hold_dir != DIR_NONE && since >= cfg_shadow.dir_hold_ms) hold_dir = DIR_NONE;
    case (hold_dir)
      DIR_UP: begin
        r.joy_y_out = JoyLow;
        r.any_activity = 1'b1;
      end
      DIR_DOWN: begin
        r.joy_y_out = JoyHigh;
        r.any_activity = 1'b1;
      end
      DIR_LEFT: begin
        r.joy_x_out = JoyLow;
        r.any_activity = 1'b1;
      end
      DIR_RIGHT: begin
        r.joy_x_out = JoyHigh;
        r.any_activity = 1'b1;
      end
      default: ;
    endcase
    if (back_timing) begin
      since = p.now_ms - back_press_stamp;
      if (since >= cfg_shadow.long_press_ms) begin
        r.long_back = 1'b1;
        back_timing = 1'b0;
      end else begin
        since = p.now_ms - back_refresh_stamp;
        if (since >= BackReleaseMs) begin
          r.short_back = 1'b1;
          r.any_activity = 1'b1;
          back_timing = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [CodeW-1:0] code_of(input cfg_reg_t which);
    case (which)
      CFG_CODE_UP:    return cfg_shadow.code_up;
      CFG_CODE_DOWN:  return cfg_shadow.code_down;
      CFG_CODE_LEFT:  return cfg_shadow.code_left;
      CFG_CODE_RIGHT: return cfg_shadow.code_right;
      CFG_CODE_OK:    return cfg_shadow.code_ok;
      default:        return cfg_shadow.code_back;
    endcase
  endfunction

  function automatic poll_t frame_poll(input logic [TimeW-1:0] at, input logic fv,
                                       input logic fr, input logic [CodeW-1:0] cmd);
    poll_t p;
    p = '0;
    p.now_ms = at;
    p.frame_valid = fv;
    p.frame_repeat = fr;
    p.frame_cmd = cmd;
    p.joy_x_in = JoyW'($urandom());
    p.joy_y_in = JoyW'($urandom());
    return p;
  endfunction

  // mostly remote-like traffic: fresh key, repeats, gaps around the thresholds
  function automatic poll_t make_random_poll();
    poll_t       p;
    int unsigned span;
    int unsigned pick;
    span = BackReleaseMs;
    if (cfg_shadow.long_press_ms > span) span = TimeW'(cfg_shadow.long_press_ms);
    if (cfg_shadow.dir_hold_ms > span) span = TimeW'(cfg_shadow.dir_hold_ms);
    pick = $urandom_range(99, 0);
    if (pick < 2) poll_ms = $urandom();
    else if (pick < 15) poll_ms += $urandom_range(2 * span, 0);
    else poll_ms += $urandom_range(130, 0);
    p = frame_poll(poll_ms, 1'b0, 1'($urandom()), CodeW'($urandom()));
    pick = $urandom_range(99, 0);
    if (pick >= 35) begin
      p.frame_valid = 1'b1;
      p.frame_repeat = (pick < 65);
      if (pick >= 65 && pick < 93)
        p.frame_cmd = code_of(cfg_reg_t'($urandom_range(CFG_CODE_BACK, CFG_CODE_UP)));
    end
    p.click_in = ($urandom_range(9, 0) == 0);
    p.short_in = ($urandom_range(9, 0) == 0);
    p.any_in = ($urandom_range(9, 0) == 0);
    return p;
  endfunction

  function automatic cfg_t make_random_cfg();
    cfg_t c;
    c.code_up = CodeW'($urandom());
    c.code_down = CodeW'($urandom());
    c.code_left = CodeW'($urandom());
    c.code_right = CodeW'($urandom());
    c.code_ok = CodeW'($urandom());
    c.code_back = CodeW'($urandom());
    c.long_press_ms = MsW'($urandom_range(2000, 0));
    c.dir_hold_ms = MsW'($urandom_range(600, 0));
    return c;
  endfunction

  task automatic send_poll(input poll_t p);
    logic took;
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      poll_bus.valid <= 1'b0;
      @(posedge clk);
    end
    poll_bus.valid <= 1'b1;
    poll_bus.item <= p;
    do begin
      @(negedge clk);
      took = poll_bus.ready;
      @(posedge clk);
    end while (!took);
    expected_results.push_back(predict_poll(p));
  endtask

  task automatic wait_drained();
    poll_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // code registers get junk in the upper data byte
  task automatic write_config(input cfg_t c);
    cfg_reg_t            idx;
    logic [CfgDataW-1:0] val;
    idx = idx.first();
    repeat (idx.num()) begin
      case (idx)
        CFG_CODE_UP:    val = {CodeW'($urandom()), c.code_up};
        CFG_CODE_DOWN:  val = {CodeW'($urandom()), c.code_down};
        CFG_CODE_LEFT:  val = {CodeW'($urandom()), c.code_left};
        CFG_CODE_RIGHT: val = {CodeW'($urandom()), c.code_right};
        CFG_CODE_OK:    val = {CodeW'($urandom()), c.code_ok};
        CFG_CODE_BACK:  val = {CodeW'($urandom()), c.code_back};
        CFG_LONG_PRESS: val = c.long_press_ms;
        default:        val = c.dir_hold_ms;
      endcase
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      @(posedge clk);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
    cfg_shadow = c;
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  initial begin : result_sink
    result_t seen;
    result_t want;
    logic    took;
    result_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      took = result_bus.valid && result_bus.ready;
      seen = result_bus.item;
      @(posedge clk);
      if (took) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing outstanding expected none got %h",
                   $time, seen);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("joy_x_out", want.joy_x_out, seen.joy_x_out);
          check_field("joy_y_out", want.joy_y_out, seen.joy_y_out);
          check_field("click_out", want.click_out, seen.click_out);
          check_field("short_back", want.short_back, seen.short_back);
          check_field("long_back", want.long_back, seen.long_back);
          check_field("any_activity", want.any_activity, seen.any_activity);
        end
      end
      if (sink_hold_left > 0) begin
        result_bus.ready <= 1'b0;
        sink_hold_left--;
      end else begin
        result_bus.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  always @(negedge clk) begin
    if ((poll_bus.valid && poll_bus.ready) || (result_bus.valid && result_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb_ir_remote_key_hold_qualifier_core failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_directed_defaults();
    poll_t p;
    send_poll(frame_poll(32'd1000, 1'b1, 1'b0, cfg_shadow.code_up));
    send_poll(frame_poll(32'd1100, 1'b1, 1'b1, 8'h00));
    send_poll(frame_poll(32'd1279, 1'b0, 1'b0, 8'h00));
    send_poll(frame_poll(32'd1280, 1'b0, 1'b0, 8'h00));
    send_poll(frame_poll(32'd1300, 1'b1, 1'b0, cfg_shadow.code_down));
    send_poll(frame_poll(32'd1310, 1'b1, 1'b0, cfg_shadow.code_left));
    send_poll(frame_poll(32'd1320, 1'b1, 1'b0, cfg_shadow.code_right));
    send_poll(frame_poll(32'd1700, 1'b1, 1'b0, cfg_shadow.code_ok));
    // repeat with nothing held, then a code nobody owns
    send_poll(frame_poll(32'd1710, 1'b1, 1'b1, cfg_shadow.code_ok));
    send_poll(frame_poll(32'd1720, 1'b1, 1'b0, 8'hFF));
    send_poll(frame_poll(32'd2000, 1'b1, 1'b0, cfg_shadow.code_back));
    send_poll(frame_poll(32'd2150, 1'b1, 1'b1, 8'h00));
    send_poll(frame_poll(32'd2349, 1'b0, 1'b0, 8'h00));
    send_poll(frame_poll(32'd2350, 1'b0, 1'b0, 8'h00));
    // long and short both due: long wins
    send_poll(frame_poll(32'd3000, 1'b1, 1'b0, cfg_shadow.code_back));
    send_poll(frame_poll(32'd3900, 1'b0, 1'b0, 8'h00));
    // hold across the 2^32 wrap
    send_poll(frame_poll(32'hFFFF_FFF0, 1'b1, 1'b0, cfg_shadow.code_left));
    send_poll(frame_poll(32'h0000_0050, 1'b1, 1'b1, 8'h00));
    p = frame_poll(32'h0000_0060, 1'b0, 1'b0, 8'h00);
    p.joy_x_in = '0;
    p.joy_y_in = '1;
    p.click_in = 1'b1;
    p.short_in = 1'b1;
    p.any_in = 1'b1;
    send_poll(p);
    p = frame_poll(32'h0000_0120, 1'b0, 1'b0, 8'h00);
    p.joy_x_in = '1;
    p.joy_y_in = '0;
    send_poll(p);
  endtask

  task automatic test_colliding_codes_and_zero_thresholds();
    cfg_t c;
    wait_drained();
    c.code_up = '0;
    c.code_down = '0;
    c.code_left = 8'h33;
    c.code_right = 8'h33;
    c.code_ok = 8'h44;
    c.code_back = 8'h44;
    c.long_press_ms = '0;
    c.dir_hold_ms = '0;
    write_config(c);
    send_poll(frame_poll(32'd6000, 1'b1, 1'b0, 8'h00));
    send_poll(frame_poll(32'd6000, 1'b1, 1'b0, 8'h33));
    send_poll(frame_poll(32'd6001, 1'b1, 1'b0, 8'h44));
    send_poll(frame_poll(32'd6002, 1'b1, 1'b1, 8'h44));
    wait_drained();
    c.code_down = 8'h01;
    c.code_left = 8'h02;
    c.code_right = 8'h03;
    c.code_ok = 8'h04;
    c.code_back = 8'h05;
    c.dir_hold_ms = '1;
    write_config(c);
    send_poll(frame_poll(32'd6100, 1'b1, 1'b0, 8'h00));
    send_poll(frame_poll(32'd6110, 1'b1, 1'b0, 8'h05));
    send_poll(frame_poll(32'd6120, 1'b1, 1'b0, 8'h03));
    send_poll(frame_poll(32'd6130, 1'b1, 1'b0, 8'h04));
  endtask

  task automatic test_code_change_while_held();
    cfg_t c;
    wait_drained();
    c = DefaultCfg;
    c.long_press_ms = '1;
    c.dir_hold_ms = '1;
    write_config(c);
    send_poll(frame_poll(32'd5000, 1'b1, 1'b0, c.code_left));
    send_poll(frame_poll(32'd5010, 1'b1, 1'b0, c.code_back));
    wait_drained();
    c.code_up = 8'h11;
    c.code_down = 8'h12;
    c.code_left = 8'h78;
    c.code_right = 8'h79;
    c.code_ok = 8'h7A;
    c.code_back = 8'h7B;
    write_config(c);
    send_poll(frame_poll(32'd5100, 1'b1, 1'b1, DefaultCfg.code_left));
    send_poll(frame_poll(32'd5110, 1'b1, 1'b0, DefaultCfg.code_left));
    send_poll(frame_poll(32'd5120, 1'b1, 1'b0, 8'h11));
    send_poll(frame_poll(32'd5400, 1'b1, 1'b0, 8'h7B));
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
                                     input cfg_t c);
    wait_drained();
    write_config(c);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_poll(make_random_poll());
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sink_hold_left = 300;
    repeat (40) send_poll(make_random_poll());
  endtask

  initial begin
    cfg_t phase_cfg;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_CODE_UP;
    cfg_data <= '0;
    poll_bus.valid <= 1'b0;
    poll_bus.item <= '0;
    cfg_shadow = DefaultCfg;
    hold_dir = DIR_NONE;
    hold_dir_stamp = '0;
    back_timing = 1'b0;
    back_press_stamp = '0;
    back_refresh_stamp = '0;
    poll_ms = '0;
    send_idle_pct = 37;
    recv_idle_pct = 68;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed_defaults();
    test_colliding_codes_and_zero_thresholds();
    test_code_change_while_held();
    test_random_traffic(400, 37, 68, DefaultCfg);
    phase_cfg = make_random_cfg();
    phase_cfg.long_press_ms = 16'd1;
    phase_cfg.dir_hold_ms = 16'd1;
    test_random_traffic(300, 68, 37, phase_cfg);
    phase_cfg = make_random_cfg();
    phase_cfg.long_press_ms = '1;
    phase_cfg.dir_hold_ms = '1;
    test_random_traffic(300, 0, 0, phase_cfg);
    test_random_traffic(300, 0, 0, make_random_cfg());
    test_output_backpressure();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("tb_ir_remote_key_hold_qualifier_core passed");
    end else begin
      $display("tb_ir_remote_key_hold_qualifier_core failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/irkh_pkg.sv
sv/irkh_if.sv
sv/irkh_cfg_regs.sv
sv/irkh_eval.sv
sv/ir_remote_key_hold_qualifier_core.sv
tb/tb_ir_remote_key_hold_qualifier_core.sv
